FILE: src/cteg_pkg.sv
// ----------------------------------------------------------------------------
// cteg_pkg - shared definitions for the chirp tone envelope generator
// Widths, register indexes, sequencer states, serial ALU transaction types and
// the quarter-wave sine table entry function.
// ----------------------------------------------------------------------------
`default_nettype none

package cteg_pkg;

	// Parameter defaults
	localparam int LENGTH_LIMIT_DEF   = 2048;
	localparam int PHASE_BITS_DEF     = 24;
	localparam int SINE_ROM_DEPTH_DEF = 256;

	// Field widths
	localparam int STEP_W   = 23;
	localparam int LEN_W    = 11;
	localparam int PEAK_W   = 15;
	localparam int STR_W    = 8;
	localparam int SAMPLE_W = 16;
	localparam int ENV_W    = 17;
	localparam int CFG_W    = 23;
	localparam int IDX_W    = 3;

	// Longest length the length registers can hold
	localparam int MAX_LEN   = 2047;
	localparam int MIN_LEN   = 8;
	localparam int ENV_ONE   = 65536;
	localparam int AMP_SHIFT = 31;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_START_STEP  = 3'd0;
	localparam logic [IDX_W-1:0] REG_END_STEP    = 3'd1;
	localparam logic [IDX_W-1:0] REG_BASE_LENGTH = 3'd2;
	localparam logic [IDX_W-1:0] REG_MAX_LENGTH  = 3'd3;
	localparam logic [IDX_W-1:0] REG_ATTACK      = 3'd4;
	localparam logic [IDX_W-1:0] REG_PEAK_LOW    = 3'd5;
	localparam logic [IDX_W-1:0] REG_PEAK_HIGH   = 3'd6;
	localparam logic [IDX_W-1:0] REG_MUTED       = 3'd7;

	// Register reset values
	localparam logic [STEP_W-1:0] START_STEP_RST = 23'd1468006;
	localparam logic [STEP_W-1:0] END_STEP_RST   = 23'd734003;
	localparam logic [LEN_W-1:0]  BASE_LEN_RST   = 11'd640;
	localparam logic [LEN_W-1:0]  MAX_LEN_RST    = 11'd1280;
	localparam logic [LEN_W-1:0]  ATTACK_RST     = 11'd48;
	localparam logic [PEAK_W-1:0] PEAK_LOW_RST   = 15'd24000;
	localparam logic [PEAK_W-1:0] PEAK_HIGH_RST  = 15'd24000;

	// Serial ALU geometry: multiplicand is added, multiplier bits are shifted out
	localparam int MUL_MC_W   = 23;
	localparam int MUL_MP_W   = 30;
	localparam int MUL_P_W    = MUL_MC_W + MUL_MP_W;
	localparam int DIV_N_W    = 34;
	localparam int DIV_D_W    = 11;
	localparam int MUL_STEPS  = MUL_MP_W;
	localparam int DIV_STEPS  = DIV_N_W;
	localparam int ALU_CNT_W  = $clog2(DIV_STEPS);
	localparam int ALU_A_W    = DIV_N_W;
	localparam int ALU_B_W    = MUL_MC_W;
	localparam logic [DIV_D_W-1:0] DIV_255 = 11'd255;

	typedef enum logic {
		OP_MUL,
		OP_DIV
	} alu_op_t;

	// opa: multiplier (low bits) or dividend; opb: multiplicand or divisor (low bits)
	typedef struct packed {
		logic               start;
		alu_op_t            op;
		logic [ALU_A_W-1:0] opa;
		logic [ALU_B_W-1:0] opb;
	} alu_cmd_t;

	typedef struct packed {
		logic               done;
		logic [MUL_P_W-1:0] prod;
		logic [DIV_N_W-1:0] quo;
		logic [DIV_D_W-1:0] rem;
	} alu_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LEN_MUL,
		ST_LEN_DIV,
		ST_PEAK_MUL,
		ST_PEAK_DIV,
		ST_ENV_DIV,
		ST_AMP_MUL,
		ST_MAG_MUL,
		ST_SLOPE_MUL,
		ST_STEP_DIV,
		ST_EMIT
	} state_t;

	// Q2.30 constants for the Taylor series
	localparam longint Q30_HALF_PI = 64'sd1686629713;
	localparam longint Q30_ONE     = 64'sd1073741824;
	localparam longint SineFull    = 64'sd32767;
	localparam longint TaylorDiv [8] = '{64'sd6, 64'sd20, 64'sd42, 64'sd72,
		64'sd110, 64'sd156, 64'sd210, 64'sd272};

	// Sine of angle x (Q2.30 radians), scaled to unsigned Q0.15 and rounded
	function automatic logic [PEAK_W-1:0] sine_entry(input longint x);
		longint term;
		longint sum;
		longint v;
		term = x;
		sum  = x;
		for (int i = 0; i < 8; i++) begin
			term = -(term * x / Q30_ONE) / TaylorDiv[i];
			term = term * x / Q30_ONE;
			sum  = sum + term;
		end
		if (sum < 0) begin
			sum = 0;
		end
		v = (sum * SineFull + Q30_ONE / 2) / Q30_ONE;
		if (v > SineFull) begin
			v = SineFull;
		end
		return v[PEAK_W-1:0];
	endfunction

endpackage

`default_nettype wire

FILE: src/cteg_serial_alu.sv
// ----------------------------------------------------------------------------
// cteg_serial_alu - radix-2 serial multiplier and restoring divider
// One multiplier bit or one quotient bit per cycle; the result holds until the
// next transaction is started.
// ----------------------------------------------------------------------------
`default_nettype none

module cteg_serial_alu (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cteg_pkg::alu_cmd_t cmd,
	output      cteg_pkg::alu_rsp_t rsp
);

	localparam int MC_W = cteg_pkg::MUL_MC_W;
	localparam int MP_W = cteg_pkg::MUL_MP_W;
	localparam int N_W  = cteg_pkg::DIV_N_W;
	localparam int D_W  = cteg_pkg::DIV_D_W;

	logic                           busy_q;
	logic                           done_q;
	cteg_pkg::alu_op_t              op_q;
	logic [cteg_pkg::ALU_CNT_W-1:0] cnt_q;
	logic [MC_W-1:0]                mc_q;
	logic [MC_W-1:0]                hi_q;
	logic [MP_W-1:0]                lo_q;
	logic [D_W-1:0]                 den_q;
	logic [D_W-1:0]                 rem_q;
	logic [N_W-1:0]                 quo_q;

	logic [MC_W:0]  mul_sum;
	logic [D_W:0]   div_trial;
	logic           div_ge;
	logic [D_W:0]   div_diff;

	// Add the multiplicand when the low multiplier bit is set
	assign mul_sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mc_q} : '0);

	// Shift in the next dividend bit and try the subtract
	assign div_trial = {rem_q, quo_q[N_W-1]};
	assign div_ge    = div_trial >= {1'b0, den_q};
	assign div_diff  = div_trial - {1'b0, den_q};

	// Control: count steps, pulse done at the end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= cteg_pkg::OP_MUL;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				op_q   <= cmd.op;
				cnt_q  <= (cmd.op == cteg_pkg::OP_MUL)
					? cteg_pkg::ALU_CNT_W'(cteg_pkg::MUL_STEPS - 1)
					: cteg_pkg::ALU_CNT_W'(cteg_pkg::DIV_STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: load operands, then advance one bit per cycle
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			mc_q  <= cmd.opb;
			hi_q  <= '0;
			lo_q  <= cmd.opa[MP_W-1:0];
			den_q <= cmd.opb[D_W-1:0];
			rem_q <= '0;
			quo_q <= cmd.opa;
		end else if (busy_q) begin
			if (op_q == cteg_pkg::OP_MUL) begin
				hi_q <= mul_sum[MC_W:1];
				lo_q <= {mul_sum[0], lo_q[MP_W-1:1]};
			end else begin
				rem_q <= div_ge ? div_diff[D_W-1:0] : div_trial[D_W-1:0];
				quo_q <= {quo_q[N_W-2:0], div_ge};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = {hi_q, lo_q};
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q;

endmodule

`default_nettype wire

FILE: src/cteg_sine_rom.sv
// ----------------------------------------------------------------------------
// cteg_sine_rom - quarter-wave sine lookup
// Picks the quadrant from the top phase bits, mirrors the table address in odd
// quadrants, flags negative half. User sets a power-of-two depth, unchecked.
// ----------------------------------------------------------------------------
`default_nettype none

module cteg_sine_rom #(
	parameter int PHASE_BITS     = cteg_pkg::PHASE_BITS_DEF,
	parameter int SINE_ROM_DEPTH = cteg_pkg::SINE_ROM_DEPTH_DEF
) (
	input  wire logic [PHASE_BITS-1:0]       phase,
	output      logic [cteg_pkg::PEAK_W-1:0] sine_mag,
	output      logic                        sine_neg
);

	localparam int AW = $clog2(SINE_ROM_DEPTH);
	localparam int QB = PHASE_BITS - 2;

	logic [cteg_pkg::PEAK_W-1:0] rom_w [SINE_ROM_DEPTH];
	logic [AW-1:0]               raw_addr;
	logic [AW-1:0]               addr;

	// Build the table at elaboration, one entry per quarter-wave step
	for (genvar k = 0; k < SINE_ROM_DEPTH; k++) begin : g_rom
		localparam longint Angle = cteg_pkg::Q30_HALF_PI * longint'(2 * k + 1)
			/ (longint'(2) * longint'(SINE_ROM_DEPTH));
		assign rom_w[k] = cteg_pkg::sine_entry(Angle);
	end

	// Top address bits of the phase within the quadrant
	assign raw_addr = phase[QB-1 -: AW];

	// Mirror in the second and fourth quadrants
	assign addr     = phase[QB] ? (AW'(SINE_ROM_DEPTH - 1) - raw_addr) : raw_addr;
	assign sine_mag = rom_w[addr];
	assign sine_neg = phase[QB+1];

endmodule

`default_nettype wire

FILE: src/chirp_tone_envelope_generator.sv
// ----------------------------------------------------------------------------
// chirp_tone_envelope_generator - chirp voice with attack/decay envelope
// Phase-accumulator sine voice whose step sweeps linearly across the sound,
// shaped by a linear rise and fall, one sample per input transaction.
// ----------------------------------------------------------------------------
// Every input transaction yields one output transaction. A tick while silent
// skips the serial unit and goes straight to the emit state. A tick during a
// sound runs one envelope division, three multiplies and one phase-step
// division one after the other on a shared serial unit that retires one bit
// per cycle. A trigger adds two multiplies and two divisions by 255 for
// length and peak. The output register lets the next transaction be accepted
// while a sample waits; the final step stalls only if that register is still
// full. Configuration writes take effect at once and belong in idle periods;
// length and peak are latched at the trigger.
// ----------------------------------------------------------------------------
`default_nettype none

module chirp_tone_envelope_generator #(
	parameter int LENGTH_LIMIT   = cteg_pkg::LENGTH_LIMIT_DEF,
	parameter int PHASE_BITS     = cteg_pkg::PHASE_BITS_DEF,
	parameter int SINE_ROM_DEPTH = cteg_pkg::SINE_ROM_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output      logic                          in_ready,
	input  wire logic                          mode,
	input  wire logic [cteg_pkg::STR_W-1:0]    strength,
	output      logic                          out_valid,
	input  wire logic                          out_ready,
	output      logic signed [cteg_pkg::SAMPLE_W-1:0] sample,
	output      logic                          active,
	output      logic                          last,
	input  wire logic                          cfg_we,
	input  wire logic [cteg_pkg::IDX_W-1:0]    cfg_index,
	input  wire logic [cteg_pkg::CFG_W-1:0]    cfg_data
);

	localparam int STEP_W = cteg_pkg::STEP_W;
	localparam int LEN_W  = cteg_pkg::LEN_W;
	localparam int PEAK_W = cteg_pkg::PEAK_W;
	localparam int ENV_W  = cteg_pkg::ENV_W;
	localparam int A_W    = cteg_pkg::ALU_A_W;
	localparam int B_W    = cteg_pkg::ALU_B_W;
	localparam int LenCapInt = (LENGTH_LIMIT - 1 < cteg_pkg::MAX_LEN)
		? LENGTH_LIMIT - 1 : cteg_pkg::MAX_LEN;
	localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(LenCapInt);

	// Configuration registers
	logic [STEP_W-1:0] start_step_q;
	logic [STEP_W-1:0] end_step_q;
	logic [LEN_W-1:0]  base_len_q;
	logic [LEN_W-1:0]  max_len_q;
	logic [LEN_W-1:0]  attack_q;
	logic [PEAK_W-1:0] peak_low_q;
	logic [PEAK_W-1:0] peak_high_q;
	logic              muted_q;

	// Voice state
	cteg_pkg::state_t  state_q;
	cteg_pkg::state_t  state_d;
	logic              fresh_q;
	logic              playing_q;
	logic [PHASE_BITS-1:0] phase_q;
	logic [LEN_W-1:0]  idx_q;
	logic [LEN_W-1:0]  len_q;
	logic [PEAK_W-1:0] peak_q;
	logic [ENV_W-1:0]  env_q;
	logic [PEAK_W-1:0] mag_q;
	logic [STEP_W-1:0] inc_q;
	logic [cteg_pkg::STR_W-1:0] str_q;

	// Output register
	logic              out_valid_q;
	logic signed [cteg_pkg::SAMPLE_W-1:0] sample_q;
	logic              active_q;
	logic              last_q;

	cteg_pkg::alu_cmd_t alu_cmd;
	cteg_pkg::alu_rsp_t alu_rsp;

	logic [PEAK_W-1:0] sine_mag;
	logic              sine_neg;

	logic              out_free;
	logic              fin;
	logic [LEN_W-1:0]  len_m1;
	logic [LEN_W-1:0]  att;
	logic              n_lt_att;
	logic signed [LEN_W:0]    dl;
	logic [LEN_W-1:0]         dl_mag;
	logic signed [PEAK_W:0]   dp;
	logic [PEAK_W-1:0]        dp_mag;
	logic signed [STEP_W:0]   diff;
	logic [STEP_W-1:0]        diff_mag;
	logic signed [LEN_W+1:0]  len_fl;
	logic signed [LEN_W+1:0]  len_x;
	logic [LEN_W-1:0]         len_d;
	logic signed [PEAK_W+1:0] peak_fl;
	logic signed [PEAK_W+1:0] peak_x;
	logic [ENV_W-1:0]         env_d;
	logic [PEAK_W-1:0]        mag_d;
	logic signed [STEP_W+1:0] inc_x;

	cteg_serial_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (alu_cmd),
		.rsp    (alu_rsp)
	);

	cteg_sine_rom #(
		.PHASE_BITS     (PHASE_BITS),
		.SINE_ROM_DEPTH (SINE_ROM_DEPTH)
	) u_sine (
		.phase    (phase_q),
		.sine_mag (sine_mag),
		.sine_neg (sine_neg)
	);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_step_q <= cteg_pkg::START_STEP_RST;
			end_step_q   <= cteg_pkg::END_STEP_RST;
			base_len_q   <= cteg_pkg::BASE_LEN_RST;
			max_len_q    <= cteg_pkg::MAX_LEN_RST;
			attack_q     <= cteg_pkg::ATTACK_RST;
			peak_low_q   <= cteg_pkg::PEAK_LOW_RST;
			peak_high_q  <= cteg_pkg::PEAK_HIGH_RST;
			muted_q      <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cteg_pkg::REG_START_STEP:  start_step_q <= cfg_data[STEP_W-1:0];
				cteg_pkg::REG_END_STEP:    end_step_q   <= cfg_data[STEP_W-1:0];
				cteg_pkg::REG_BASE_LENGTH: base_len_q   <= cfg_data[LEN_W-1:0];
				cteg_pkg::REG_MAX_LENGTH:  max_len_q    <= cfg_data[LEN_W-1:0];
				cteg_pkg::REG_ATTACK:      attack_q     <= cfg_data[LEN_W-1:0];
				cteg_pkg::REG_PEAK_LOW:    peak_low_q   <= cfg_data[PEAK_W-1:0];
				cteg_pkg::REG_PEAK_HIGH:   peak_high_q  <= cfg_data[PEAK_W-1:0];
				cteg_pkg::REG_MUTED:       muted_q      <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Envelope geometry: attack limited to one..length minus one
	assign len_m1   = len_q - 1'b1;
	always_comb begin
		att = attack_q;
		if (att == '0) begin
			att = LEN_W'(1);
		end
		if (att > len_m1) begin
			att = len_m1;
		end
	end
	assign n_lt_att = idx_q < att;
	assign fin      = idx_q >= len_m1;

	// Signed spans and their magnitudes
	assign dl       = $signed({1'b0, max_len_q}) - $signed({1'b0, base_len_q});
	assign dl_mag   = dl[LEN_W] ? LEN_W'(-dl) : dl[LEN_W-1:0];
	assign dp       = $signed({1'b0, peak_high_q}) - $signed({1'b0, peak_low_q});
	assign dp_mag   = dp[PEAK_W] ? PEAK_W'(-dp) : dp[PEAK_W-1:0];
	assign diff     = $signed({1'b0, end_step_q}) - $signed({1'b0, start_step_q});
	assign diff_mag = diff[STEP_W] ? STEP_W'(-diff) : diff[STEP_W-1:0];

	// Length: floor division by 255, then the three clamps in order
	always_comb begin
		len_fl = $signed({1'b0, alu_rsp.quo[LEN_W:0]});
		if (dl[LEN_W]) begin
			len_fl = -($signed({1'b0, alu_rsp.quo[LEN_W:0]})
				+ $signed({(LEN_W+1)'(0), alu_rsp.rem != '0}));
		end
		len_x = $signed({2'b00, base_len_q}) + len_fl;
		if (len_x > $signed({2'b00, max_len_q})) begin
			len_x = $signed({2'b00, max_len_q});
		end
		if (len_x < $signed((LEN_W+2)'(cteg_pkg::MIN_LEN))) begin
			len_x = $signed((LEN_W+2)'(cteg_pkg::MIN_LEN));
		end
		if (len_x > $signed({2'b00, LEN_CAP})) begin
			len_x = $signed({2'b00, LEN_CAP});
		end
		len_d = len_x[LEN_W-1:0];
	end

	// Peak: same floor division, result stays between the two registers
	always_comb begin
		peak_fl = $signed({1'b0, alu_rsp.quo[PEAK_W:0]});
		if (dp[PEAK_W]) begin
			peak_fl = -($signed({1'b0, alu_rsp.quo[PEAK_W:0]})
				+ $signed({(PEAK_W+1)'(0), alu_rsp.rem != '0}));
		end
		peak_x = $signed({2'b00, peak_low_q}) + peak_fl;
	end

	// Envelope from the quotient, amplitude from the product, step from the quotient
	assign env_d = n_lt_att ? alu_rsp.quo[ENV_W-1:0]
		: ENV_W'(cteg_pkg::ENV_ONE) - alu_rsp.quo[ENV_W-1:0];
	assign mag_d = alu_rsp.prod[cteg_pkg::AMP_SHIFT+PEAK_W] ? {PEAK_W{1'b1}}
		: alu_rsp.prod[cteg_pkg::AMP_SHIFT +: PEAK_W];
	assign inc_x = diff[STEP_W]
		? $signed({2'b00, start_step_q}) - $signed({2'b00, alu_rsp.quo[STEP_W-1:0]})
		: $signed({2'b00, start_step_q}) + $signed({2'b00, alu_rsp.quo[STEP_W-1:0]});

	assign out_free = !out_valid_q || out_ready;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cteg_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (mode && !muted_q) begin
						state_d = cteg_pkg::ST_LEN_MUL;
					end else if (playing_q) begin
						state_d = cteg_pkg::ST_ENV_DIV;
					end else begin
						state_d = cteg_pkg::ST_EMIT;
					end
				end
			end
			cteg_pkg::ST_LEN_MUL:   if (alu_rsp.done) state_d = cteg_pkg::ST_LEN_DIV;
			cteg_pkg::ST_LEN_DIV:   if (alu_rsp.done) state_d = cteg_pkg::ST_PEAK_MUL;
			cteg_pkg::ST_PEAK_MUL:  if (alu_rsp.done) state_d = cteg_pkg::ST_PEAK_DIV;
			cteg_pkg::ST_PEAK_DIV:  if (alu_rsp.done) state_d = cteg_pkg::ST_ENV_DIV;
			cteg_pkg::ST_ENV_DIV:   if (alu_rsp.done) state_d = cteg_pkg::ST_AMP_MUL;
			cteg_pkg::ST_AMP_MUL:   if (alu_rsp.done) state_d = cteg_pkg::ST_MAG_MUL;
			cteg_pkg::ST_MAG_MUL:   if (alu_rsp.done) state_d = cteg_pkg::ST_SLOPE_MUL;
			cteg_pkg::ST_SLOPE_MUL: if (alu_rsp.done) state_d = cteg_pkg::ST_STEP_DIV;
			cteg_pkg::ST_STEP_DIV:  if (alu_rsp.done) state_d = cteg_pkg::ST_EMIT;
			cteg_pkg::ST_EMIT:      if (out_free) state_d = cteg_pkg::ST_IDLE;
			default:                state_d = cteg_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: handshake and ALU transaction
	always_comb begin
		in_ready      = state_q == cteg_pkg::ST_IDLE;
		alu_cmd.start = 1'b0;
		alu_cmd.op    = cteg_pkg::OP_MUL;
		alu_cmd.opa   = '0;
		alu_cmd.opb   = '0;
		unique case (state_q)
			cteg_pkg::ST_LEN_MUL: begin
				alu_cmd.start = fresh_q;
				alu_cmd.opa   = A_W'(str_q);
				alu_cmd.opb   = B_W'(dl_mag);
			end
			cteg_pkg::ST_PEAK_MUL: begin
				alu_cmd.start = fresh_q;
				alu_cmd.opa   = A_W'(str_q);
				alu_cmd.opb   = B_W'(dp_mag);
			end
			cteg_pkg::ST_LEN_DIV, cteg_pkg::ST_PEAK_DIV: begin
				alu_cmd.start = fresh_q;
				alu_cmd.op    = cteg_pkg::OP_DIV;
				alu_cmd.opa   = alu_rsp.prod[A_W-1:0];
				alu_cmd.opb   = B_W'(cteg_pkg::DIV_255);
			end
			cteg_pkg::ST_ENV_DIV: begin
				alu_cmd.start = fresh_q;
				alu_cmd.op    = cteg_pkg::OP_DIV;
				alu_cmd.opa   = n_lt_att ? A_W'({idx_q, 16'h0000})
					: A_W'({idx_q - att, 16'h0000});
				alu_cmd.opb   = n_lt_att ? B_W'(att) : B_W'(len_q - att);
			end
			cteg_pkg::ST_AMP_MUL: begin
				alu_cmd.start = fresh_q;
				alu_cmd.opa   = A_W'(sine_mag);
				alu_cmd.opb   = B_W'(peak_q);
			end
			cteg_pkg::ST_MAG_MUL: begin
				alu_cmd.start = fresh_q;
				alu_cmd.opa   = A_W'(alu_rsp.prod[cteg_pkg::MUL_MP_W-1:0]);
				alu_cmd.opb   = B_W'(env_q);
			end
			cteg_pkg::ST_SLOPE_MUL: begin
				alu_cmd.start = fresh_q;
				alu_cmd.opa   = A_W'(idx_q);
				alu_cmd.opb   = B_W'(diff_mag);
			end
			cteg_pkg::ST_STEP_DIV: begin
				alu_cmd.start = fresh_q;
				alu_cmd.op    = cteg_pkg::OP_DIV;
				alu_cmd.opa   = alu_rsp.prod[A_W-1:0];
				alu_cmd.opb   = B_W'(len_m1);
			end
			cteg_pkg::ST_IDLE, cteg_pkg::ST_EMIT: begin
			end
			default: begin
			end
		endcase
	end

	// Sequencer and voice control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= cteg_pkg::ST_IDLE;
			fresh_q   <= 1'b0;
			playing_q <= 1'b0;
			phase_q   <= '0;
			idx_q     <= '0;
			len_q     <= '0;
			peak_q    <= '0;
		end else begin
			state_q <= state_d;
			fresh_q <= state_d != state_q;
			// Latch length, then peak and restart the voice
			if (state_q == cteg_pkg::ST_LEN_DIV && alu_rsp.done) begin
				len_q <= len_d;
			end
			if (state_q == cteg_pkg::ST_PEAK_DIV && alu_rsp.done) begin
				peak_q    <= peak_x[PEAK_W-1:0];
				phase_q   <= '0;
				idx_q     <= '0;
				playing_q <= 1'b1;
			end
			// Advance phase and index once the sample is loaded into the output register
			if (state_q == cteg_pkg::ST_EMIT && out_free && playing_q) begin
				phase_q <= phase_q + PHASE_BITS'(inc_q);
				if (fin) begin
					playing_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	// Hold strength and intermediate results
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			str_q <= strength;
		end
		if (state_q == cteg_pkg::ST_ENV_DIV && alu_rsp.done) begin
			env_q <= env_d;
		end
		if (state_q == cteg_pkg::ST_MAG_MUL && alu_rsp.done) begin
			mag_q <= mag_d;
		end
		if (state_q == cteg_pkg::ST_STEP_DIV && alu_rsp.done) begin
			inc_q <= inc_x[STEP_W-1:0];
		end
	end

	// Output register: load on emit, drop on transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == cteg_pkg::ST_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == cteg_pkg::ST_EMIT && out_free) begin
			if (playing_q) begin
				sample_q <= sine_neg ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
				active_q <= 1'b1;
				last_q   <= fin;
			end else begin
				sample_q <= '0;
				active_q <= 1'b0;
				last_q   <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign sample    = sample_q;
	assign active    = active_q;
	assign last      = last_q;

endmodule

`default_nettype wire
